// ===== hw/rtl/lobl_pkg.sv =====
// ----------------------------------------------------------------------------
// lobl_pkg
// Shared constants, codes and record types of the limit order book core.
// ----------------------------------------------------------------------------
package lobl_pkg;

  // Book dimensions.
  localparam int MAX_ORDERS      = 4096;
  localparam int LEVELS_PER_SIDE = 256;
  localparam int PRICE_BITS      = 20;
  localparam int NUM_LEVELS      = 2 * LEVELS_PER_SIDE;

  // Derived widths.
  localparam int SLOT_W  = $clog2(MAX_ORDERS);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int ORD_W   = $clog2(MAX_ORDERS + 1);
  localparam int TOTAL_W = 48;
  localparam int ID_W    = 32;
  localparam int QTY_W   = 32;
  localparam int SCAN_MAX = (MAX_ORDERS > NUM_LEVELS) ? MAX_ORDERS : NUM_LEVELS;
  localparam int CNT_W   = $clog2(SCAN_MAX + 1);

  // A link equal to MAX_ORDERS means no neighbor.
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_ORDERS);

  // Command codes.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // One accepted command word, classified by the front end.
  typedef struct packed {
    logic                  cmd;
    logic [ID_W-1:0]       id;
    logic                  buy;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_W-1:0]      qty;
    logic                  bad;
  } cmd_t;

  // Order slot record.
  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
    logic [LVL_W-1:0] lvl;
  } slot_rec_t;

  // Price level record.
  typedef struct packed {
    logic                  used;
    logic [PRICE_BITS-1:0] price;
    logic [TOTAL_W-1:0]    total;
    logic [ORD_W-1:0]      orders;
  } level_rec_t;

  // Top of one side of the book as reported.
  typedef struct packed {
    logic        valid;
    logic [19:0] price;
    logic [47:0] total;
    logic [12:0] count;
    logic [31:0] head_id;
  } side_t;

  // One result word.
  typedef struct packed {
    logic [2:0] status;
    side_t      bid;
    side_t      ask;
  } res_t;

endpackage

// ===== hw/rtl/lobl_front.sv =====
// ----------------------------------------------------------------------------
// lobl_front
// Accepts command words, flags adds with a zero price or quantity and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lobl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [31:0]                     in_order_id,
  input  logic                            in_buy_side,
  input  logic [lobl_pkg::PRICE_BITS-1:0] in_price,
  input  logic [31:0]                     in_quantity,
  input  logic                            clearing_i,
  output logic                            q_valid_o,
  output lobl_pkg::cmd_t                  q_cmd_o,
  input  logic                            q_ready_i
);
  import lobl_pkg::*;

  cmd_t       fifo_r [2];
  logic       wp_r;
  logic       wp_nxt;
  logic       rp_r;
  logic       rp_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  // Classify the incoming word.
  always_comb begin
    new_cmd.cmd   = in_cmd;
    new_cmd.id    = in_order_id;
    new_cmd.buy   = in_buy_side;
    new_cmd.price = in_price;
    new_cmd.qty   = in_quantity;
    new_cmd.bad   = (in_cmd == CMD_ADD) && ((in_price == '0) || (in_quantity == '0));
  end

  // No word is taken while the queue is full or the tables are being cleared.
  assign in_stall  = (cnt_r == 2'd2) || clearing_i;
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_r != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_cmd_o   = fifo_r[rp_r];

  // Queue pointers and fill count.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= new_cmd;
    end
  end

endmodule

// ===== hw/rtl/lobl_back.sv =====
// ----------------------------------------------------------------------------
// lobl_back
// Sequencer that owns the slot and level tables, carries out each command
// by scanning and relinking, then searches both sides for the best level.
// ----------------------------------------------------------------------------
module lobl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid_i,
  input  lobl_pkg::cmd_t q_cmd_i,
  output logic           q_ready_o,
  output logic           clearing_o,
  output logic           out_valid,
  input  logic           out_stall,
  output lobl_pkg::res_t res_o
);
  import lobl_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SSCAN = 4'd2;
  localparam logic [3:0] S_SDEC  = 4'd3;
  localparam logic [3:0] S_LSCAN = 4'd4;
  localparam logic [3:0] S_LDEC  = 4'd5;
  localparam logic [3:0] S_ADD1  = 4'd6;
  localparam logic [3:0] S_ADD2  = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CWR   = 4'd9;
  localparam logic [3:0] S_BSCAN = 4'd10;
  localparam logic [3:0] S_HBID  = 4'd11;
  localparam logic [3:0] S_HASK  = 4'd12;
  localparam logic [3:0] S_HEND  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Tables.
  slot_rec_t          slot_mem [MAX_ORDERS];
  logic [LINK_W-1:0]  prev_mem [MAX_ORDERS];
  logic [LINK_W-1:0]  next_mem [MAX_ORDERS];
  level_rec_t         lvl_mem  [NUM_LEVELS];
  logic [SLOT_W-1:0]  head_mem [NUM_LEVELS];
  logic [SLOT_W-1:0]  tail_mem [NUM_LEVELS];

  // Table ports.
  logic [SLOT_W-1:0]  s_ra;
  logic [LVL_W-1:0]   l_ra;
  slot_rec_t          sm_q;
  logic [LINK_W-1:0]  pm_q;
  logic [LINK_W-1:0]  nm_q;
  level_rec_t         lm_q;
  logic [SLOT_W-1:0]  hm_q;
  logic [SLOT_W-1:0]  tm_q;
  logic               sm_we;
  logic [SLOT_W-1:0]  sm_wa;
  slot_rec_t          sm_wd;
  logic               pm_we;
  logic [SLOT_W-1:0]  pm_wa;
  logic [LINK_W-1:0]  pm_wd;
  logic               nm_we;
  logic [SLOT_W-1:0]  nm_wa;
  logic [LINK_W-1:0]  nm_wd;
  logic               lm_we;
  logic [LVL_W-1:0]   lm_wa;
  level_rec_t         lm_wd;
  logic               hm_we;
  logic [LVL_W-1:0]   hm_wa;
  logic [SLOT_W-1:0]  hm_wd;
  logic               tm_we;
  logic [LVL_W-1:0]   tm_wa;
  logic [SLOT_W-1:0]  tm_wd;

  // Sequencer state.
  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pv_r, pv_nxt;
  logic [CNT_W-1:0]   pidx_r, pidx_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [2:0]         st_r, st_nxt;

  // Slot scan results.
  logic               hit_r, hit_nxt;
  logic [SLOT_W-1:0]  hidx_r, hidx_nxt;
  logic [QTY_W-1:0]   hqty_r, hqty_nxt;
  logic [LVL_W-1:0]   hlvl_r, hlvl_nxt;
  logic [LINK_W-1:0]  hprev_r, hprev_nxt;
  logic [LINK_W-1:0]  hnext_r, hnext_nxt;
  logic               sfree_r, sfree_nxt;
  logic [SLOT_W-1:0]  fs_r, fs_nxt;

  // Level scan results.
  logic               lhit_r, lhit_nxt;
  logic [LVL_W-1:0]   lv_r, lv_nxt;
  logic [TOTAL_W-1:0] ltot_r, ltot_nxt;
  logic [ORD_W-1:0]   lord_r, lord_nxt;
  logic [SLOT_W-1:0]  ltail_r, ltail_nxt;
  logic               lfree_r, lfree_nxt;
  logic [LVL_W-1:0]   flv_r, flv_nxt;

  // Best level search results.
  logic                  bv_r, bv_nxt;
  logic [PRICE_BITS-1:0] bp_r, bp_nxt;
  logic [TOTAL_W-1:0]    bt_r, bt_nxt;
  logic [ORD_W-1:0]      bc_r, bc_nxt;
  logic [SLOT_W-1:0]     bh_r, bh_nxt;
  logic                  av_r, av_nxt;
  logic [PRICE_BITS-1:0] ap_r, ap_nxt;
  logic [TOTAL_W-1:0]    at_r, at_nxt;
  logic [ORD_W-1:0]      ac_r, ac_nxt;
  logic [SLOT_W-1:0]     ah_r, ah_nxt;
  logic [ID_W-1:0]       bid_id_r, bid_id_nxt;
  logic [ID_W-1:0]       ask_id_r, ask_id_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  // Arithmetic helpers.
  logic [LVL_W-1:0]   lbase;
  logic [TOTAL_W:0]   add_sum;
  logic [TOTAL_W-1:0] add_total;
  logic [TOTAL_W-1:0] cxl_total;
  logic [ORD_W-1:0]   cxl_orders;
  logic [LVL_W-1:0]   scan_lvl;
  logic               go_best;

  assign lbase      = cmd_r.buy ? '0 : LVL_W'(LEVELS_PER_SIDE);
  assign add_sum    = {1'b0, ltot_r} + (TOTAL_W + 1)'(cmd_r.qty);
  assign add_total  = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
  assign cxl_total  = (lm_q.total >= TOTAL_W'(hqty_r)) ? (lm_q.total - TOTAL_W'(hqty_r)) : '0;
  assign cxl_orders = (lm_q.orders != '0) ? (lm_q.orders - ORD_W'(1)) : '0;

  assign q_ready_o  = (state_r == S_IDLE);
  assign clearing_o = (state_r == S_CLEAR);
  assign out_valid  = out_valid_r;
  assign res_o      = res_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    cmd_nxt    = cmd_r;
    st_nxt     = st_r;
    hit_nxt    = hit_r;
    hidx_nxt   = hidx_r;
    hqty_nxt   = hqty_r;
    hlvl_nxt   = hlvl_r;
    hprev_nxt  = hprev_r;
    hnext_nxt  = hnext_r;
    sfree_nxt  = sfree_r;
    fs_nxt     = fs_r;
    lhit_nxt   = lhit_r;
    lv_nxt     = lv_r;
    ltot_nxt   = ltot_r;
    lord_nxt   = lord_r;
    ltail_nxt  = ltail_r;
    lfree_nxt  = lfree_r;
    flv_nxt    = flv_r;
    bv_nxt     = bv_r;
    bp_nxt     = bp_r;
    bt_nxt     = bt_r;
    bc_nxt     = bc_r;
    bh_nxt     = bh_r;
    av_nxt     = av_r;
    ap_nxt     = ap_r;
    at_nxt     = at_r;
    ac_nxt     = ac_r;
    ah_nxt     = ah_r;
    bid_id_nxt = bid_id_r;
    ask_id_nxt = ask_id_r;
    res_nxt    = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    go_best    = 1'b0;
    scan_lvl   = '0;

    s_ra  = '0;
    l_ra  = '0;
    sm_we = 1'b0;
    sm_wa = '0;
    sm_wd = '0;
    pm_we = 1'b0;
    pm_wa = '0;
    pm_wd = '0;
    nm_we = 1'b0;
    nm_wa = '0;
    nm_wd = '0;
    lm_we = 1'b0;
    lm_wa = '0;
    lm_wd = '0;
    hm_we = 1'b0;
    hm_wa = '0;
    hm_wd = '0;
    tm_we = 1'b0;
    tm_wa = '0;
    tm_wd = '0;

    case (state_r)
      // Clear the used flags of every slot and level after reset.
      S_CLEAR: begin
        sm_we   = 1'b1;
        sm_wa   = cnt_r[SLOT_W-1:0];
        if (cnt_r < CNT_W'(NUM_LEVELS)) begin
          lm_we = 1'b1;
          lm_wa = cnt_r[LVL_W-1:0];
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_ORDERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take the next command word from the queue.
      S_IDLE: begin
        if (q_valid_i) begin
          cmd_nxt = q_cmd_i;
          st_nxt  = ST_OK;
          if (q_cmd_i.bad) begin
            st_nxt  = ST_ZERO;
            go_best = 1'b1;
          end else begin
            cnt_nxt   = '0;
            hit_nxt   = 1'b0;
            sfree_nxt = 1'b0;
            state_nxt = S_SSCAN;
          end
        end
      end

      // Walk all slots: find the id and the lowest free slot.
      S_SSCAN: begin
        s_ra = cnt_r[SLOT_W-1:0];
        if (cnt_r < CNT_W'(MAX_ORDERS)) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r;
        end
        if (pv_r) begin
          if (sm_q.used) begin
            if (sm_q.id == cmd_r.id && !hit_r) begin
              hit_nxt   = 1'b1;
              hidx_nxt  = pidx_r[SLOT_W-1:0];
              hqty_nxt  = sm_q.qty;
              hlvl_nxt  = sm_q.lvl;
              hprev_nxt = pm_q;
              hnext_nxt = nm_q;
            end
          end else if (!sfree_r) begin
            sfree_nxt = 1'b1;
            fs_nxt    = pidx_r[SLOT_W-1:0];
          end
          if (pidx_r == CNT_W'(MAX_ORDERS - 1)) begin
            state_nxt = S_SDEC;
          end
        end
      end

      // Decide what the id lookup means for this command.
      S_SDEC: begin
        if (cmd_r.cmd == CMD_CANCEL) begin
          if (!hit_r) begin
            st_nxt  = ST_UNKNOWN;
            go_best = 1'b1;
          end else begin
            state_nxt = S_CRD;
          end
        end else if (hit_r) begin
          st_nxt  = ST_DUP;
          go_best = 1'b1;
        end else begin
          cnt_nxt   = '0;
          lhit_nxt  = 1'b0;
          lfree_nxt = 1'b0;
          state_nxt = S_LSCAN;
        end
      end

      // Walk the levels of the order's side: matching price and free level.
      S_LSCAN: begin
        l_ra = lbase + cnt_r[LVL_W-1:0];
        if (cnt_r < CNT_W'(LEVELS_PER_SIDE)) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r;
        end
        if (pv_r) begin
          scan_lvl = lbase + pidx_r[LVL_W-1:0];
          if (lm_q.used) begin
            if (lm_q.price == cmd_r.price && !lhit_r) begin
              lhit_nxt  = 1'b1;
              lv_nxt    = scan_lvl;
              ltot_nxt  = lm_q.total;
              lord_nxt  = lm_q.orders;
              ltail_nxt = tm_q;
            end
          end else if (!lfree_r) begin
            lfree_nxt = 1'b1;
            flv_nxt   = scan_lvl;
          end
          if (pidx_r == CNT_W'(LEVELS_PER_SIDE - 1)) begin
            state_nxt = S_LDEC;
          end
        end
      end

      // Check capacity and pick the level for the new order.
      S_LDEC: begin
        if (!sfree_r || (!lhit_r && !lfree_r)) begin
          st_nxt  = ST_FULL;
          go_best = 1'b1;
        end else begin
          if (!lhit_r) begin
            lv_nxt   = flv_r;
            ltot_nxt = '0;
            lord_nxt = '0;
          end
          state_nxt = S_ADD1;
        end
      end

      // Write the new slot and update the level record.
      S_ADD1: begin
        sm_we       = 1'b1;
        sm_wa       = fs_r;
        sm_wd.used  = 1'b1;
        sm_wd.id    = cmd_r.id;
        sm_wd.qty   = cmd_r.qty;
        sm_wd.lvl   = lv_r;
        nm_we       = 1'b1;
        nm_wa       = fs_r;
        nm_wd       = NO_LINK;
        pm_we       = 1'b1;
        pm_wa       = fs_r;
        pm_wd       = (lord_r == '0) ? NO_LINK : LINK_W'(ltail_r);
        lm_we       = 1'b1;
        lm_wa       = lv_r;
        lm_wd.used   = 1'b1;
        lm_wd.price  = cmd_r.price;
        lm_wd.total  = add_total;
        lm_wd.orders = lord_r + ORD_W'(1);
        tm_we       = 1'b1;
        tm_wa       = lv_r;
        tm_wd       = fs_r;
        if (lord_r == '0) begin
          hm_we   = 1'b1;
          hm_wa   = lv_r;
          hm_wd   = fs_r;
          go_best = 1'b1;
        end else begin
          state_nxt = S_ADD2;
        end
      end

      // Link the old tail forward to the new order.
      S_ADD2: begin
        nm_we   = 1'b1;
        nm_wa   = ltail_r;
        nm_wd   = LINK_W'(fs_r);
        go_best = 1'b1;
      end

      // Read the level record of the cancelled order.
      S_CRD: begin
        l_ra      = hlvl_r;
        state_nxt = S_CWR;
      end

      // Unlink the order and update or free its level.
      S_CWR: begin
        if (hprev_r != NO_LINK) begin
          nm_we = 1'b1;
          nm_wa = hprev_r[SLOT_W-1:0];
          nm_wd = hnext_r;
        end else begin
          hm_we = 1'b1;
          hm_wa = hlvl_r;
          hm_wd = hnext_r[SLOT_W-1:0];
        end
        if (hnext_r != NO_LINK) begin
          pm_we = 1'b1;
          pm_wa = hnext_r[SLOT_W-1:0];
          pm_wd = hprev_r;
        end else begin
          tm_we = 1'b1;
          tm_wa = hlvl_r;
          tm_wd = hprev_r[SLOT_W-1:0];
        end
        lm_we        = 1'b1;
        lm_wa        = hlvl_r;
        lm_wd.used   = (cxl_orders != '0);
        lm_wd.price  = lm_q.price;
        lm_wd.total  = cxl_total;
        lm_wd.orders = cxl_orders;
        sm_we        = 1'b1;
        sm_wa        = hidx_r;
        go_best      = 1'b1;
      end

      // Walk every level: highest bid and lowest ask.
      S_BSCAN: begin
        l_ra = cnt_r[LVL_W-1:0];
        if (cnt_r < CNT_W'(NUM_LEVELS)) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r;
        end
        if (pv_r) begin
          if (pidx_r < CNT_W'(LEVELS_PER_SIDE)) begin
            if (lm_q.used && (!bv_r || lm_q.price > bp_r)) begin
              bv_nxt = 1'b1;
              bp_nxt = lm_q.price;
              bt_nxt = lm_q.total;
              bc_nxt = lm_q.orders;
              bh_nxt = hm_q;
            end
          end else begin
            if (lm_q.used && (!av_r || lm_q.price < ap_r)) begin
              av_nxt = 1'b1;
              ap_nxt = lm_q.price;
              at_nxt = lm_q.total;
              ac_nxt = lm_q.orders;
              ah_nxt = hm_q;
            end
          end
          if (pidx_r == CNT_W'(NUM_LEVELS - 1)) begin
            state_nxt = S_HBID;
          end
        end
      end

      // Fetch the head order ids of both best levels.
      S_HBID: begin
        s_ra      = bh_r;
        state_nxt = S_HASK;
      end

      S_HASK: begin
        s_ra       = ah_r;
        bid_id_nxt = bv_r ? sm_q.id : '0;
        state_nxt  = S_HEND;
      end

      S_HEND: begin
        ask_id_nxt = av_r ? sm_q.id : '0;
        state_nxt  = S_OUT;
      end

      // Hand the result word over once the result register is free.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          res_nxt.status        = st_r;
          res_nxt.bid.valid     = bv_r;
          res_nxt.bid.price     = bv_r ? bp_r : '0;
          res_nxt.bid.total     = bv_r ? bt_r : '0;
          res_nxt.bid.count     = bv_r ? bc_r : '0;
          res_nxt.bid.head_id   = bid_id_r;
          res_nxt.ask.valid     = av_r;
          res_nxt.ask.price     = av_r ? ap_r : '0;
          res_nxt.ask.total     = av_r ? at_r : '0;
          res_nxt.ask.count     = av_r ? ac_r : '0;
          res_nxt.ask.head_id   = ask_id_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Common start of the best level search.
    if (go_best) begin
      cnt_nxt   = '0;
      bv_nxt    = 1'b0;
      av_nxt    = 1'b0;
      state_nxt = S_BSCAN;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    cmd_r    <= cmd_nxt;
    st_r     <= st_nxt;
    hit_r    <= hit_nxt;
    hidx_r   <= hidx_nxt;
    hqty_r   <= hqty_nxt;
    hlvl_r   <= hlvl_nxt;
    hprev_r  <= hprev_nxt;
    hnext_r  <= hnext_nxt;
    sfree_r  <= sfree_nxt;
    fs_r     <= fs_nxt;
    lhit_r   <= lhit_nxt;
    lv_r     <= lv_nxt;
    ltot_r   <= ltot_nxt;
    lord_r   <= lord_nxt;
    ltail_r  <= ltail_nxt;
    lfree_r  <= lfree_nxt;
    flv_r    <= flv_nxt;
    bv_r     <= bv_nxt;
    bp_r     <= bp_nxt;
    bt_r     <= bt_nxt;
    bc_r     <= bc_nxt;
    bh_r     <= bh_nxt;
    av_r     <= av_nxt;
    ap_r     <= ap_nxt;
    at_r     <= at_nxt;
    ac_r     <= ac_nxt;
    ah_r     <= ah_nxt;
    bid_id_r <= bid_id_nxt;
    ask_id_r <= ask_id_nxt;
    res_r    <= res_nxt;
  end

  // Slot tables: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (sm_we) begin
      slot_mem[sm_wa] <= sm_wd;
    end
    sm_q <= slot_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      prev_mem[pm_wa] <= pm_wd;
    end
    pm_q <= prev_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      next_mem[nm_wa] <= nm_wd;
    end
    nm_q <= next_mem[s_ra];
  end

  // Level tables.
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lvl_mem[lm_wa] <= lm_wd;
    end
    lm_q <= lvl_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      head_mem[hm_wa] <= hm_wd;
    end
    hm_q <= head_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tail_mem[tm_wa] <= tm_wd;
    end
    tm_q <= tail_mem[l_ra];
  end

  // A cancelled order always sits on a level in use.
  a_cancel_level_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CWR |-> lm_q.used)
    else $error("cancel found its level unused");

  // The second add step only runs when the level already held orders.
  a_add2_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD2 |-> lord_r != '0)
    else $error("tail link step on an empty level");

  // A new result word appears only from the hand-over state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result word raised outside hand-over");

  // A reported best bid always holds orders at a nonzero price.
  a_best_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.bid.valid |-> res_r.bid.price != '0 && res_r.bid.count != '0)
    else $error("best bid reported empty");

endmodule

// ===== hw/rtl/limit_order_book_levels_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_levels_core
// Two-sided order book with price levels kept in arrival order; reports the
// best bid and best ask after each add or cancel command.
// ----------------------------------------------------------------------------
// Each command word is carried out by sequential passes over the tables
// through their single read ports: the id lookup walks all MAX_ORDERS slots,
// an add then walks the LEVELS_PER_SIDE levels of its side, and the
// best-price search walks all 2*LEVELS_PER_SIDE levels. An add with a zero
// price or quantity skips the id lookup and the level walk. A two-entry input
// queue and a result register let both channels stall independently. After
// reset the tables are cleared, during which in_stall is high.
module limit_order_book_levels_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_order_id,
  input  logic        in_buy_side,
  input  logic [19:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_bid_valid,
  output logic [19:0] out_bid_price,
  output logic [47:0] out_bid_total,
  output logic [12:0] out_bid_count,
  output logic [31:0] out_bid_head_id,
  output logic        out_ask_valid,
  output logic [19:0] out_ask_price,
  output logic [47:0] out_ask_total,
  output logic [12:0] out_ask_count,
  output logic [31:0] out_ask_head_id
);
  import lobl_pkg::*;

  logic q_valid;
  logic q_ready;
  logic clearing;
  cmd_t q_cmd;
  res_t res;

  // Front end: accept and classify command words.
  lobl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_order_id (in_order_id),
    .in_buy_side (in_buy_side),
    .in_price    (in_price),
    .in_quantity (in_quantity),
    .clearing_i  (clearing),
    .q_valid_o   (q_valid),
    .q_cmd_o     (q_cmd),
    .q_ready_i   (q_ready)
  );

  // Back end: table updates and best level search.
  lobl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_ready_o  (q_ready),
    .clearing_o (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_o      (res)
  );

  // Result word fields.
  assign out_status      = res.status;
  assign out_bid_valid   = res.bid.valid;
  assign out_bid_price   = res.bid.price;
  assign out_bid_total   = res.bid.total;
  assign out_bid_count   = res.bid.count;
  assign out_bid_head_id = res.bid.head_id;
  assign out_ask_valid   = res.ask.valid;
  assign out_ask_price   = res.ask.price;
  assign out_ask_total   = res.ask.total;
  assign out_ask_count   = res.ask.count;
  assign out_ask_head_id = res.ask.head_id;

endmodule
